/* hw/rtl/lcs_length_assert.svh */
// Assertion macros shared by the LCS length block.
`ifndef LCS_LENGTH_ASSERT_SVH
`define LCS_LENGTH_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lcs_pkg.sv */
package lcs_pkg;

  // Longest string held for either side
  localparam int MAX_LEN   = 64;
  // Fill counts reach MAX_LEN itself
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  // Address into a string store
  localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  // Score values never exceed MAX_LEN
  localparam int LEN_W     = CNT_W;
  // Width of the reported length
  localparam int OUT_LEN_W = 7;
  localparam int SYM_W     = 8;

  // Request opcodes
  typedef enum logic [1:0] {
    ACT_FIRST   = 2'd0,
    ACT_SECOND  = 2'd1,
    ACT_COMPUTE = 2'd2
  } lcs_action_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [SYM_W-1:0] symbol;
  } lcs_in_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] subsequence_length;
    logic                 truncated;
  } lcs_out_t;

  // One row of the score table moving along the cell chain
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] left;
    logic [LEN_W-1:0] diag;
  } lcs_tok_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic clear_score;
    logic clear_text;
  } lcs_cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lcs_state_t;

  // Clamp a score to the reported width
  function automatic logic [OUT_LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'd127) begin
      return OUT_LEN_W'(127);
    end
    return w[OUT_LEN_W-1:0];
  endfunction

endpackage

/* hw/rtl/lcs_cell.sv */
module lcs_cell
  import lcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lcs_cell_ctl_t    ctl,
  input  logic             load,
  input  logic [SYM_W-1:0] load_sym,
  input  lcs_tok_t         tok_in,
  output lcs_tok_t         tok_out
);

  logic [SYM_W-1:0] sym_r;
  logic             loaded_r;
  logic [LEN_W-1:0] score_r;
  logic [LEN_W-1:0] val_w;
  lcs_tok_t         tok_r;
  lcs_tok_t         tok_nxt;

  // Score for this column of the passing row; an empty cell passes left on
  always_comb begin
    if (!loaded_r) begin
      val_w = tok_in.left;
    end else if (tok_in.sym == sym_r) begin
      val_w = tok_in.diag + LEN_W'(1);
    end else if (score_r > tok_in.left) begin
      val_w = score_r;
    end else begin
      val_w = tok_in.left;
    end
  end

  always_comb begin
    tok_nxt       = tok_in;
    tok_nxt.left  = val_w;
    tok_nxt.diag  = score_r;
  end

  // Hold this column's byte of the second string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
    end else if (ctl.clear_text) begin
      loaded_r <= 1'b0;
    end else if (load) begin
      loaded_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sym_r <= load_sym;
    end
  end

  // Keep the upper value for the next row
  always_ff @(posedge clk) begin
    if (ctl.clear_score) begin
      score_r <= '0;
    end else if (tok_in.valid && loaded_r) begin
      score_r <= val_w;
    end
  end

  // Hand the row on to the neighbour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

/* hw/rtl/lcs_feed.sv */
module lcs_feed
  import lcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [SYM_W-1:0] wr_sym,
  input  logic             start,
  input  lcs_cell_ctl_t    ctl,
  output logic             full,
  output logic             empty,
  output lcs_tok_t         tok_out
);

  logic [SYM_W-1:0] mem [MAX_LEN];
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  logic             run_r;
  logic             last_idx_w;
  logic [SYM_W-1:0] rd_sym_r;
  logic             tv_r;
  logic             tlast_r;

  assign full       = (count_r == CNT_W'(MAX_LEN));
  assign empty      = (count_r == '0);
  assign last_idx_w = (CNT_W'(idx_r) == count_r - CNT_W'(1));

  // Store the first string
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[count_r[IDX_W-1:0]] <= wr_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clear_text) begin
      count_r <= '0;
    end else if (wr_en && !full) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // Walk the stored bytes, one row per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      idx_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      idx_r <= '0;
    end else if (run_r) begin
      if (last_idx_w) begin
        run_r <= 1'b0;
      end
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (run_r) begin
      rd_sym_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r    <= 1'b0;
      tlast_r <= 1'b0;
    end else begin
      tv_r    <= run_r;
      tlast_r <= run_r && last_idx_w;
    end
  end

  // Rows enter the chain with a zero left boundary
  always_comb begin
    tok_out       = '0;
    tok_out.valid = tv_r;
    tok_out.last  = tlast_r;
    tok_out.sym   = rd_sym_r;
  end

endmodule

/* hw/rtl/lcs_length.sv */
// Channel  | Ports                        | Moves
// ---------+------------------------------+-------------------------------------
// input    | in_valid, in_stall, in_data  | append to first/second string, compute
// output   | out_valid, out_stall, out_data | LCS length and truncation flag
//
// Appends are accepted while a result waits at the output.
// A compute whose strings are both non-empty reads the first-string store, one row per
// cycle (m rows, m = length of the first string), and then waits for the last row to
// cross the cell chain of MAX_LEN cells. An empty string gives its result without a
// pass through the chain. A compute is held off while the previous result is unread.
// Reset is synchronous, active low; the string stores need no clearing pass.
`include "lcs_length_assert.svh"

module lcs_length
  import lcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lcs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lcs_out_t out_data
);

  lcs_state_t       state_r;
  lcs_state_t       state_nxt;
  logic [CNT_W-1:0] second_count_r;
  logic             dropped_r;
  logic             out_valid_r;
  lcs_out_t         out_data_r;
  logic             accept_w;
  logic             is_first_w;
  logic             is_second_w;
  logic             is_compute_w;
  logic             second_full_w;
  logic             first_full_w;
  logic             first_empty_w;
  logic             empty_w;
  logic             done_w;
  logic             feed_start_w;
  logic             finish_w;
  lcs_cell_ctl_t    ctl_w;
  lcs_tok_t         tok_w [MAX_LEN+1];

  // Decode the request
  always_comb begin
    is_first_w   = 1'b0;
    is_second_w  = 1'b0;
    is_compute_w = 1'b0;
    unique case (in_data.action)
      ACT_FIRST:   is_first_w   = 1'b1;
      ACT_SECOND:  is_second_w  = 1'b1;
      ACT_COMPUTE: is_compute_w = 1'b1;
      default:     ;
    endcase
  end

  assign in_stall      = (state_r != ST_IDLE) || (is_compute_w && out_valid_r);
  assign accept_w      = in_valid && !in_stall;
  assign second_full_w = (second_count_r == CNT_W'(MAX_LEN));
  assign empty_w       = first_empty_w || (second_count_r == '0);
  assign done_w        = tok_w[MAX_LEN].valid && tok_w[MAX_LEN].last;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_w && is_compute_w && !empty_w) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done_w) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    feed_start_w = 1'b0;
    finish_w     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        feed_start_w = accept_w && is_compute_w && !empty_w;
        finish_w     = accept_w && is_compute_w && empty_w;
      end
      ST_RUN: begin
        finish_w = done_w;
      end
      default: ;
    endcase
  end

  always_comb begin
    ctl_w.clear_score = feed_start_w;
    ctl_w.clear_text  = finish_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Track the second string length and dropped appends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_count_r <= '0;
      dropped_r      <= 1'b0;
    end else if (finish_w) begin
      second_count_r <= '0;
      dropped_r      <= 1'b0;
    end else if (accept_w) begin
      if (is_second_w && !second_full_w) begin
        second_count_r <= second_count_r + CNT_W'(1);
      end
      if ((is_second_w && second_full_w) || (is_first_w && first_full_w)) begin
        dropped_r <= 1'b1;
      end
    end
  end

  lcs_feed u_feed (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept_w && is_first_w),
    .wr_sym  (in_data.symbol),
    .start   (feed_start_w),
    .ctl     (ctl_w),
    .full    (first_full_w),
    .empty   (first_empty_w),
    .tok_out (tok_w[0])
  );

  // Chain of cells, one per column of the second string
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lcs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl_w),
      .load     (accept_w && is_second_w && (second_count_r == CNT_W'(k))),
      .load_sym (in_data.symbol),
      .tok_in   (tok_w[k]),
      .tok_out  (tok_w[k+1])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_w) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_w) begin
      out_data_r.subsequence_length <= (state_r == ST_RUN) ?
                                       sat_len(tok_w[MAX_LEN].left) : '0;
      out_data_r.truncated          <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LCS_ASSERT_NOW(a_done_in_run, done_w, state_r == ST_RUN,
                  "row end seen outside a compute")
  `LCS_ASSERT_NEXT(a_start_runs, feed_start_w, state_r == ST_RUN,
                   "compute start did not enter run state")
  `LCS_ASSERT_NEXT(a_finish_clears, finish_w,
                   (second_count_r == '0) && !dropped_r && out_valid_r,
                   "compute end left stale string state")

endmodule

/* tb/testbench.sv */
module testbench
  import lcs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Action code the block leaves unused; it must be ignored
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_TARGET   = 1850;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 2 * MAX_LEN + 16;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lcs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lcs_out_t out_data;

  lcs_length DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the two stored strings, their fill counts and the drop flag
  logic [SYM_W-1:0] first_bytes [MAX_LEN];
  logic [SYM_W-1:0] second_bytes [MAX_LEN];
  int               first_fill;
  int               second_fill;
  bit               bytes_dropped;
  lcs_out_t         pending_lengths [$];

  int  mismatches = 0;
  int  requests_sent = 0;
  bit  send_quiet = 1'b0;
  bit  recv_quiet = 1'b0;
  int  hold_asked = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  recv_wait = 0;

  // Longest common subsequence of the stored strings, one score row at a time
  function automatic lcs_out_t lcs_of_stored();
    int       row [MAX_LEN + 1];
    int       diag;
    int       up;
    int       score;
    lcs_out_t res;
    for (int j = 0; j <= second_fill; j++) row[j] = 0;
    for (int i = 0; i < first_fill; i++) begin
      diag = 0;
      for (int j = 1; j <= second_fill; j++) begin
        up = row[j];
        if (first_bytes[i] == second_bytes[j-1]) begin
          score = diag + 1;
        end else begin
          score = (up > row[j-1]) ? up : row[j-1];
        end
        diag = up;
        row[j] = score;
      end
    end
    score = row[second_fill];
    if (score > 127) score = 127;
    res.subsequence_length = OUT_LEN_W'(score);
    res.truncated = bytes_dropped;
    return res;
  endfunction

  // Apply one accepted request to the predictor
  task automatic predict_request(input logic [1:0] act, input logic [SYM_W-1:0] sym);
    if (act == ACT_FIRST) begin
      if (first_fill < MAX_LEN) begin
        first_bytes[first_fill] = sym;
        first_fill++;
      end else begin
        bytes_dropped = 1'b1;
      end
    end else if (act == ACT_SECOND) begin
      if (second_fill < MAX_LEN) begin
        second_bytes[second_fill] = sym;
        second_fill++;
      end else begin
        bytes_dropped = 1'b1;
      end
    end else if (act == ACT_COMPUTE) begin
      pending_lengths.push_back(lcs_of_stored());
      first_fill = 0;
      second_fill = 0;
      bytes_dropped = 1'b0;
    end
  endtask

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input logic [1:0] act, input logic [SYM_W-1:0] sym);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, symbol: sym};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(act, sym);
    if (act != ACT_UNUSED) requests_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lengths.size() != 0) @(posedge clk);
  endtask

  // Fill both strings in random interleaved order, with some noise, then compute
  task automatic send_sequence(input int first_n, input int second_n, input int letters);
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] sym;
    int               left_a;
    int               left_b;
    base = SYM_W'($urandom_range(0, 255));
    left_a = first_n;
    left_b = second_n;
    while (left_a + left_b > 0) begin
      if (letters == 0) sym = SYM_W'($urandom_range(0, 255));
      else sym = base + SYM_W'($urandom_range(0, letters - 1));
      if ($urandom_range(0, 15) == 0) begin
        send_request(ACT_UNUSED, SYM_W'($urandom_range(0, 255)));
      end else if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 0)) begin
        send_request(ACT_FIRST, sym);
        left_a--;
      end else begin
        send_request(ACT_SECOND, sym);
        left_b--;
      end
    end
    send_request(ACT_COMPUTE, SYM_W'($urandom_range(0, 255)));
    // Occasionally follow with a compute on freshly cleared strings
    if ($urandom_range(0, 15) == 0) send_request(ACT_COMPUTE, SYM_W'($urandom_range(0, 255)));
  endtask

  // Empty strings, single bytes at the symbol extremes and the unused action
  task automatic test_directed();
    send_request(ACT_COMPUTE, 8'h00);
    send_request(ACT_FIRST, 8'h00);
    send_request(ACT_COMPUTE, 8'hFF);
    send_request(ACT_SECOND, 8'hFF);
    send_request(ACT_COMPUTE, 8'h00);
    send_request(ACT_FIRST, 8'hFF);
    send_request(ACT_SECOND, 8'hFF);
    send_request(ACT_COMPUTE, 8'hFF);
    send_request(ACT_FIRST, 8'h00);
    send_request(ACT_SECOND, 8'hFF);
    send_request(ACT_COMPUTE, 8'h00);
    send_request(ACT_UNUSED, 8'hAA);
    send_request(ACT_FIRST, 8'h55);
    send_request(ACT_UNUSED, 8'h55);
    send_request(ACT_SECOND, 8'h55);
    send_request(ACT_COMPUTE, 8'hAA);
    send_request(ACT_FIRST, 8'hA5);
    send_request(ACT_FIRST, 8'h5A);
    send_request(ACT_SECOND, 8'h5A);
    send_request(ACT_SECOND, 8'hA5);
    send_request(ACT_COMPUTE, 8'h00);
    wait_drained();
  endtask

  // Full strings, the longest possible match and bytes dropped on either side
  task automatic test_overflow();
    logic [SYM_W-1:0] text [MAX_LEN + 1];
    send_sequence(MAX_LEN + 6, 5, 4);
    send_sequence(3, MAX_LEN + 8, 0);
    for (int rep = 0; rep < 2; rep++) begin
      for (int k = 0; k <= MAX_LEN; k++) text[k] = SYM_W'($urandom_range(0, 255));
      for (int k = 0; k < MAX_LEN + rep; k++) send_request(ACT_FIRST, text[k]);
      for (int k = 0; k < MAX_LEN + rep; k++) send_request(ACT_SECOND, text[k]);
      send_request(ACT_COMPUTE, text[0]);
    end
    wait_drained();
  endtask

  // Hold off the output for a long stretch while computes keep arriving
  task automatic test_backpressure();
    hold_asked <= hold_asked + 1;
    for (int s = 0; s < 6; s++) begin
      send_sequence($urandom_range(1, 6), $urandom_range(1, 6), 3);
    end
    wait_drained();
  endtask

  // Random sequences, mostly short, some long, alphabets narrow and wide
  task automatic test_random();
    int pick;
    int letters;
    while (requests_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) send_quiet = !send_quiet;
      case ($urandom_range(0, 3))
        0: letters = 0;
        1: letters = 2;
        2: letters = 4;
        default: letters = 16;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        send_sequence($urandom_range(0, 8), $urandom_range(0, 8), letters);
      end else if (pick < 97) begin
        send_sequence($urandom_range(0, 24), $urandom_range(0, 24), letters);
      end else begin
        send_sequence($urandom_range(0, MAX_LEN), $urandom_range(0, MAX_LEN), letters);
      end
    end
    send_quiet = 1'b0;
    wait_drained();
  endtask

  // Receiver: random stall after each result, quiet stretches, long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (out_valid && !out_stall) begin
        recv_wait = recv_quiet ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 31) == 0) recv_quiet = !recv_quiet;
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      if (hold_left != 0) hold_left--;
      out_stall <= (hold_left != 0) || (recv_wait != 0);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    lcs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_lengths.size() == 0) begin
        $error("unexpected result: subsequence_length %0d, truncated %0d",
               out_data.subsequence_length, out_data.truncated);
        mismatches++;
      end else begin
        want = pending_lengths.pop_front();
        if (out_data.subsequence_length !== want.subsequence_length) begin
          $error("subsequence_length: expected %0d, got %0d",
                 want.subsequence_length, out_data.subsequence_length);
          mismatches++;
        end
        if (out_data.truncated !== want.truncated) begin
          $error("truncated: expected %0d, got %0d", want.truncated, out_data.truncated);
          mismatches++;
        end
      end
    end
  end

  // End the run when neither channel moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[lcs_length] ERROR");
    $finish;
  end

  initial begin
    first_fill = 0;
    second_fill = 0;
    bytes_dropped = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    // Let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_lengths.size() == 0) begin
      $display("[lcs_length] OK");
    end else begin
      $display("[lcs_length] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_cell.sv
hw/rtl/lcs_feed.sv
hw/rtl/lcs_length.sv
tb/testbench.sv
